### src/pfs_pkg.sv
// Package for the palette fade step block: request codes, control state
// encoding and the per-byte fade arithmetic. No dependencies.
`default_nettype none

package pfs_pkg;

  typedef enum logic [1:0] {
    REQ_WR_CUR = 2'd0,
    REQ_WR_TGT = 2'd1,
    REQ_RD_CUR = 2'd2,
    REQ_FADE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_FADE = 3'b100
  } state_e;

  localparam int unsigned StepW = 7;
  localparam int unsigned WordW = 32;

  // Move a signed byte toward its target by step, clamped there unless it wraps.
  function automatic logic [7:0] fade_byte(logic [7:0] cur, logic [7:0] tgt,
                                           logic [StepW-1:0] step);
    logic [7:0] nb;
    nb = 8'h00;
    if ($signed(cur) < $signed(tgt)) begin
      nb = cur + {1'b0, step};
      if ($signed(tgt) < $signed(nb)) begin
        nb = tgt;
      end
    end else begin
      nb = cur - {1'b0, step};
      if ($signed(nb) <= $signed(tgt)) begin
        nb = tgt;
      end
    end
    return nb;
  endfunction

  // Fade colour bytes 3, 2 and 0; keep byte 1.
  function automatic logic [WordW-1:0] fade_word(logic [WordW-1:0] cur,
                                                 logic [WordW-1:0] tgt,
                                                 logic [StepW-1:0] step);
    return {fade_byte(cur[31:24], tgt[31:24], step),
            fade_byte(cur[23:16], tgt[23:16], step),
            cur[15:8],
            fade_byte(cur[7:0], tgt[7:0], step)};
  endfunction

endpackage

`default_nettype wire

### src/palette_fade_step.sv
// Top level of the palette fade step block: control, scan pipeline and
// output register. Depends on pfs_pkg and pfs_ram.
`default_nettype none

// Channel  Dir  Handshake              Payload
// -------  ---  ---------------------  ---------------------------------------
// in       in   in_valid_i/in_stall_o  req_type_i, entry_index_i, entry_value_i
// out      out  out_valid_o/out_stall_i read_value_o, changed_o
// cfg      in   cfg_valid_i/cfg_ready_o cfg_data_i (step size)
//
// A write item is done when accepted; its result is registered the next cycle.
// A read item goes through the registered RAM read and then loads the output
// register. A fade pass reads each entry in turn and writes back the one read
// before, through the single read and write port of the current palette RAM.
// Reset clears control state and sets the step size to 1; palette RAMs are
// not cleared and hold unknown words until written.
// A new item is taken only in idle and when the output register is free or
// being emptied in that same cycle; a stalled result simply holds.

module palette_fade_step
  import pfs_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           req_type_i,
  input  wire logic [7:0]           entry_index_i,
  input  wire logic [31:0]          entry_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [31:0]          read_value_o,
  output logic                      changed_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [StepW-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned IW = (AW > 8) ? AW : 8;

  state_e            state_q, state_d;
  logic [StepW-1:0]  step_q;
  logic [AW:0]       scan_q, scan_d;       // next entry to read in a pass
  logic              pend_q, pend_d;       // RAM data for pend_addr_q arrives now
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  logic              chg_q, chg_d;
  logic              ok_q, ok_d;           // read item addressed a real entry
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  read_value_q, read_value_d;
  logic              changed_q, changed_d;

  logic              in_acc;
  logic              idx_ok;
  logic [IW-1:0]     idx_w;
  logic [AW-1:0]     addr_in;
  req_e              req;

  logic              cur_we, tgt_we;
  logic [AW-1:0]     cur_waddr, raddr;
  logic [WordW-1:0]  cur_wdata, cur_rdata, tgt_rdata;
  logic              diff;

  assign req     = req_e'(req_type_i);
  assign idx_w   = IW'(entry_index_i);
  assign addr_in = idx_w[AW-1:0];
  assign idx_ok  = 32'(entry_index_i) < 32'(PALETTE_ENTRIES);

  // Take an item only in idle with room in the output register.
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  assign diff = cur_rdata != tgt_rdata;

  pfs_ram #(.WIDTH(WordW), .DEPTH(PALETTE_ENTRIES)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .raddr_i (raddr),
    .rdata_o (cur_rdata)
  );

  pfs_ram #(.WIDTH(WordW), .DEPTH(PALETTE_ENTRIES)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (tgt_we),
    .waddr_i (addr_in),
    .wdata_i (entry_value_i),
    .raddr_i (raddr),
    .rdata_o (tgt_rdata)
  );

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    chg_d        = chg_q;
    ok_d         = ok_q;
    out_valid_d  = out_valid_q && out_stall_i;
    read_value_d = read_value_q;
    changed_d    = changed_q;
    raddr        = addr_in;
    cur_we       = 1'b0;
    cur_waddr    = addr_in;
    cur_wdata    = entry_value_i;
    tgt_we       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (req)
            REQ_WR_CUR, REQ_WR_TGT: begin
              // Write now and post an all-zero result.
              cur_we       = (req == REQ_WR_CUR) && idx_ok;
              tgt_we       = (req == REQ_WR_TGT) && idx_ok;
              out_valid_d  = 1'b1;
              read_value_d = '0;
              changed_d    = 1'b0;
            end
            REQ_RD_CUR: begin
              ok_d    = idx_ok;
              state_d = ST_READ;
            end
            REQ_FADE: begin
              // Issue the read of entry 0 and start the scan at entry 1.
              raddr       = '0;
              pend_d      = 1'b1;
              pend_addr_d = '0;
              scan_d      = (AW+1)'(1);
              chg_d       = 1'b0;
              state_d     = ST_FADE;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        out_valid_d  = 1'b1;
        read_value_d = ok_q ? cur_rdata : '0;
        changed_d    = 1'b0;
        state_d      = ST_IDLE;
      end
      ST_FADE: begin
        // Read entry scan_q while writing back the entry read last cycle.
        raddr = scan_q[AW-1:0];
        if (scan_q < (AW+1)'(PALETTE_ENTRIES)) begin
          pend_d      = 1'b1;
          pend_addr_d = scan_q[AW-1:0];
          scan_d      = scan_q + (AW+1)'(1);
        end
        cur_waddr = pend_addr_q;
        cur_wdata = fade_word(cur_rdata, tgt_rdata, step_q);
        if (pend_q) begin
          cur_we = diff;
          chg_d  = chg_q || diff;
          if (pend_addr_q == AW'(PALETTE_ENTRIES - 1)) begin
            out_valid_d  = 1'b1;
            read_value_d = '0;
            changed_d    = chg_q || diff;
            state_d      = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= StepW'(1);
      scan_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        step_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q  <= pend_addr_d;
    chg_q        <= chg_d;
    ok_q         <= ok_d;
    read_value_q <= read_value_d;
    changed_q    <= changed_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign changed_o    = changed_q;

endmodule

`default_nettype wire

### src/pfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module pfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/pfs_checker.sv
// Port-level checker for palette_fade_step and its bind statement.
// Depends on pfs_pkg.
`default_nettype none

module pfs_checker
  import pfs_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  req_type_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] read_value_o,
  input wire logic        changed_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_value_o)
                                   && $stable(changed_o))
    else $error("stalled result changed or dropped");

  // A result never carries both a read word and a changed flag.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(changed_o && (read_value_o != 32'd0)))
    else $error("result mixes read word and changed flag");

  // Reads and fade passes occupy the block for at least the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ((req_type_i == REQ_RD_CUR) || (req_type_i == REQ_FADE))
    |=> in_stall_o)
    else $error("accepted item while a read or pass is under way");

  // A write posts its result in the next cycle.
  a_wr_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ((req_type_i == REQ_WR_CUR) || (req_type_i == REQ_WR_TGT))
    |=> out_valid_o && !changed_o && (read_value_o == 32'd0))
    else $error("write item gave no zero result");

endmodule

bind palette_fade_step pfs_checker u_pfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .req_type_i   (req_type_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_value_o (read_value_o),
  .changed_o    (changed_o)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// Testbench for palette_fade_step: sends palette requests and step-size writes,
// predicts every reply from a local copy of both palettes. Depends on pfs_pkg.

module tb;
  import pfs_pkg::*;

  localparam int unsigned Entries       = 256;
  localparam int unsigned RandomItems   = 40;
  localparam int unsigned PhaseCount    = 5;
  localparam int unsigned WatchdogLimit = 4000;

  typedef struct packed {
    logic [WordW-1:0] read_value;
    logic             changed;
  } reply_t;

  // Every input starts at a known value before the first edge.
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [1:0]       req_type_i    = REQ_WR_CUR;
  logic [7:0]       entry_index_i = 8'h00;
  logic [31:0]      entry_value_i = 32'h0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [31:0]      read_value_o;
  logic             changed_o;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [StepW-1:0] cfg_data_i    = '0;

  // Local palette copies and step size, updated as each item is accepted.
  logic [WordW-1:0] cur_words [Entries];
  logic [WordW-1:0] tgt_words [Entries];
  logic [StepW-1:0] fade_step = 7'd1;

  reply_t      expected_replies [$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on      = 1'b1;
  bit          stalls_on    = 1'b1;

  always #5 clk_i = ~clk_i;

  palette_fade_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .changed_o     (changed_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Move one colour byte toward its target. Both bytes are signed; the sum
  // wraps at 8 bits, so a large step can land on the far side of the range.
  function automatic logic [7:0] approach_byte(logic [7:0] cur, logic [7:0] tgt,
                                               logic [StepW-1:0] step);
    int         c_val;
    int         t_val;
    logic [7:0] moved;
    c_val = int'($signed(cur));
    t_val = int'($signed(tgt));
    if (c_val < t_val) begin
      moved = cur + {1'b0, step};
      if (int'($signed(moved)) > t_val) begin
        moved = tgt;
      end
    end else begin
      // Taken also when the byte already sits on its target.
      moved = cur - {1'b0, step};
      if (int'($signed(moved)) <= t_val) begin
        moved = tgt;
      end
    end
    return moved;
  endfunction

  // Byte 1 passes through untouched; bytes 3, 2 and 0 approach the target.
  function automatic logic [WordW-1:0] faded_entry(logic [WordW-1:0] cur,
                                                   logic [WordW-1:0] tgt);
    return {approach_byte(cur[31:24], tgt[31:24], fade_step),
            approach_byte(cur[23:16], tgt[23:16], fade_step),
            cur[15:8],
            approach_byte(cur[7:0], tgt[7:0], fade_step)};
  endfunction

  // Apply one accepted request to the local palettes and queue its reply.
  task automatic predict_reply(req_e kind, logic [7:0] idx, logic [WordW-1:0] val);
    reply_t reply;
    int     i;
    reply = '0;
    case (kind)
      REQ_WR_CUR: cur_words[idx] = val;
      REQ_WR_TGT: tgt_words[idx] = val;
      REQ_RD_CUR: reply.read_value = cur_words[idx];
      default: begin
        for (i = 0; i < Entries; i++) begin
          if (cur_words[i] !== tgt_words[i]) begin
            cur_words[i] = faded_entry(cur_words[i], tgt_words[i]);
            reply.changed = 1'b1;
          end
        end
      end
    endcase
    expected_replies.push_back(reply);
  endtask

  // Offer one item and hold it until accepted. Runs from a rising edge.
  // Valid is left high afterwards so the next item can follow back to back.
  task automatic send_item(req_e kind, logic [7:0] idx, logic [WordW-1:0] val);
    if (gaps_on && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    entry_index_i <= idx;
    entry_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    predict_reply(kind, idx, val);
  endtask

  // Drop valid and wait until every reply is back and the block has settled.
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the step size; only done with the block idle.
  task automatic set_step(logic [StepW-1:0] step);
    drain_replies();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= step;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    fade_step = step;
  endtask

  // Randomly perturb some bytes of a word by a few counts, or keep it.
  function automatic logic [WordW-1:0] nudge_word(logic [WordW-1:0] base);
    logic [WordW-1:0] w;
    logic [7:0]       delta;
    int               k;
    w = base;
    if ($urandom_range(0, 2) != 0) begin
      for (k = 0; k < 4; k++) begin
        if ($urandom_range(0, 1) == 1) begin
          delta = 8'($urandom_range(0, 8));
          w[8*k +: 8] = w[8*k +: 8] + delta - 8'd4;
        end
      end
    end
    return w;
  endfunction

  // Fill both stores so no later read or fade pass touches an unwritten
  // entry. Targets equal currents, so the palette starts out settled.
  task automatic test_load_palettes();
    logic [WordW-1:0] w;
    int               i;
    for (i = 0; i < Entries; i++) begin
      if (i == 0) begin
        w = 32'h0000_0000;
      end else if (i == Entries - 1) begin
        w = 32'hffff_ffff;
      end else begin
        w = $urandom();
      end
      send_item(REQ_WR_CUR, i[7:0], w);
      send_item(REQ_WR_TGT, i[7:0], w);
    end
  endtask

  // Read back the extreme entries and one in the middle.
  task automatic test_read_back();
    send_item(REQ_RD_CUR, 8'd0, 32'hffff_ffff);
    send_item(REQ_RD_CUR, 8'd255, 32'h0000_0000);
    send_item(REQ_RD_CUR, 8'd128, $urandom());
  endtask

  // A pass over a settled palette reports no change.
  task automatic test_fade_settled();
    send_item(REQ_FADE, 8'd0, 32'h0);
  endtask

  // Unit step: a signed move toward a target across the sign boundary, a byte
  // already on target while its neighbors differ, and a byte 1 that differs.
  task automatic test_fade_unit_step();
    send_item(REQ_WR_CUR, 8'd1, 32'h0122_8000);
    send_item(REQ_WR_TGT, 8'd1, 32'h0033_7f00);
    send_item(REQ_WR_CUR, 8'd3, 32'h8055_0080);
    send_item(REQ_WR_TGT, 8'd3, 32'h80aa_0080);
    send_item(REQ_FADE, 8'd255, 32'hffff_ffff);
    send_item(REQ_FADE, 8'd0, 32'h0);
    send_item(REQ_RD_CUR, 8'd1, 32'h0);
    send_item(REQ_RD_CUR, 8'd3, 32'h0);
  endtask

  // Largest step: an upward wrap carries a byte past its target.
  task automatic test_fade_wrap();
    set_step(7'd127);
    send_item(REQ_WR_CUR, 8'd2, 32'h7000_9010);
    send_item(REQ_WR_TGT, 8'd2, 32'h7fff_7f0f);
    send_item(REQ_FADE, 8'd2, 32'h0);
    send_item(REQ_RD_CUR, 8'd2, 32'h0);
    send_item(REQ_RD_CUR, 8'd3, 32'h0);
  endtask

  // Zero step: nothing moves, yet the pass still reports a difference.
  task automatic test_zero_step();
    set_step(7'd0);
    send_item(REQ_FADE, 8'd0, 32'h0);
    send_item(REQ_RD_CUR, 8'd2, 32'h0);
    set_step(7'd1);
  endtask

  // Random traffic in phases, each with its own step size. Most writes copy
  // the other store's word with small nudges so passes converge entries;
  // the rest are raw words. One phase runs with no idling on either side.
  task automatic test_random_traffic();
    logic [StepW-1:0] step;
    logic [7:0]       idx;
    int unsigned      r;
    int               phase;
    int               n;
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       step = 7'd1;
        1:       step = StepW'($urandom_range(2, 8));
        2:       step = 7'd127;
        3:       step = StepW'($urandom_range(1, 127));
        default: step = StepW'($urandom_range(1, 4));
      endcase
      set_step(step);
      gaps_on   = (phase != 3);
      stalls_on = (phase != 3);
      for (n = 0; n < RandomItems / PhaseCount; n++) begin
        r   = $urandom_range(0, 99);
        idx = 8'($urandom_range(0, Entries - 1));
        if (r < 20) begin
          send_item(REQ_WR_TGT, idx, nudge_word(cur_words[idx]));
        end else if (r < 40) begin
          send_item(REQ_WR_CUR, idx, nudge_word(tgt_words[idx]));
        end else if (r < 50) begin
          send_item(r[0] ? REQ_WR_CUR : REQ_WR_TGT, idx, $urandom());
        end else if (r < 70) begin
          send_item(REQ_RD_CUR, idx, $urandom());
        end else begin
          send_item(REQ_FADE, idx, $urandom());
        end
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Reply side: compare each accepted reply with the oldest expectation,
  // then pick the next stall. Also count cycles in which nothing moves.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          $error("reply with nothing expected: read_value %h changed %b",
                 read_value_o, changed_o);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          if (read_value_o !== want.read_value) begin
            $error("read_value expected %h actual %h", want.read_value, read_value_o);
            error_count++;
          end
          if (changed_o !== want.changed) begin
            $error("changed expected %b actual %b", want.changed, changed_o);
            error_count++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      out_stall_i <= stalls_on && ($urandom_range(0, 99) < 25);
    end
  end

  // Stop a hung run.
  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("palette_fade_step verification failed");
    $finish;
  end

  // Hold reset, run each test in turn, then drain and report.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_palettes();
    test_read_back();
    test_fade_settled();
    test_fade_unit_step();
    test_fade_wrap();
    test_zero_step();
    test_random_traffic();
    drain_replies();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("palette_fade_step verification clean");
    end else begin
      $display("palette_fade_step verification failed");
    end
    $finish;
  end

endmodule
